// ===== rtl/core/qic_pkg.sv =====
// qic_pkg: shared widths and constants for the quotient interval count unit
`timescale 1ns / 1ps
package qic_pkg;
  localparam int X_W           = 54;
  localparam int U_W           = 64;
  localparam int FRACTION_BITS = 30;
  localparam int MUL_W         = 64;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int DIV_W         = X_W + FRACTION_BITS;
  localparam int Q_W           = 64;
  localparam int SQ_STEPS      = (X_W + 1) / 2;
  localparam int MUL_LAT       = 2;
  localparam logic [U_W-1:0] U_RESET = U_W'(1) << FRACTION_BITS;
  localparam logic [X_W-1:0] COUNT_MAX = '1;
endpackage

// ===== rtl/core/qic_mul.sv =====
// qic_mul: two-stage 64 by 64 multiplier built from four 32 by 32 partial products
`timescale 1ns / 1ps
module qic_mul (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qic_pkg::MUL_W-1:0] a,
  input  logic [qic_pkg::MUL_W-1:0] b,
  output logic [qic_pkg::PROD_W-1:0] p
);
  import qic_pkg::*;
  localparam int H = MUL_W / 2;

  logic [MUL_W-1:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;

  always_comb begin
    p_nxt = PROD_W'(pp00_r) + (PROD_W'(pp01_r) << H) + (PROD_W'(pp10_r) << H)
          + (PROD_W'(pp11_r) << MUL_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= MUL_W'(a[H-1:0]) * MUL_W'(b[H-1:0]);
      pp01_r <= MUL_W'(a[H-1:0]) * MUL_W'(b[MUL_W-1:H]);
      pp10_r <= MUL_W'(a[MUL_W-1:H]) * MUL_W'(b[H-1:0]);
      pp11_r <= MUL_W'(a[MUL_W-1:H]) * MUL_W'(b[MUL_W-1:H]);
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;
endmodule

// ===== rtl/core/qic_div.sv =====
// qic_div: restoring divider pipelined one quotient bit per stage, saturated quotient
`timescale 1ns / 1ps
module qic_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qic_pkg::DIV_W-1:0]  num,
  input  logic [qic_pkg::PROD_W-1:0] den,
  output logic [qic_pkg::Q_W-1:0]    quo
);
  import qic_pkg::*;

  logic [DIV_W-1:0] rem_r [DIV_W];
  logic [DIV_W-1:0] nq_r  [DIV_W];
  logic [DIV_W-1:0] dlo_r [DIV_W];
  logic             big_r [DIV_W];
  logic [DIV_W-1:0] rem_nxt [DIV_W];
  logic [DIV_W-1:0] nq_nxt  [DIV_W];
  logic [DIV_W-1:0] dlo_nxt [DIV_W];
  logic             big_nxt [DIV_W];

  always_comb begin
    for (int s = 0; s < DIV_W; s++) begin
      logic [DIV_W-1:0] rem_in, nq_in, dlo_in, trial;
      logic             big_in, ge;
      if (s == 0) begin
        rem_in = '0;
        nq_in  = num;
        dlo_in = den[DIV_W-1:0];
        big_in = |den[PROD_W-1:DIV_W];
      end else begin
        rem_in = rem_r[s-1];
        nq_in  = nq_r[s-1];
        dlo_in = dlo_r[s-1];
        big_in = big_r[s-1];
      end
      trial      = {rem_in[DIV_W-2:0], nq_in[DIV_W-1]};
      ge         = !big_in && (trial >= dlo_in);
      rem_nxt[s] = ge ? (trial - dlo_in) : trial;
      nq_nxt[s]  = {nq_in[DIV_W-2:0], ge};
      dlo_nxt[s] = dlo_in;
      big_nxt[s] = big_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      dlo_r <= dlo_nxt;
      big_r <= big_nxt;
    end
  end

  assign quo = (|nq_r[DIV_W-1][DIV_W-1:Q_W]) ? '1 : nq_r[DIV_W-1][Q_W-1:0];
endmodule

// ===== rtl/core/qic_sqrt.sv =====
// qic_sqrt: digit-by-digit integer square root pipelined one root bit per stage
`timescale 1ns / 1ps
module qic_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qic_pkg::X_W-1:0]     n_in,
  output logic [qic_pkg::SQ_STEPS-1:0] root
);
  import qic_pkg::*;

  logic [X_W-1:0] n_r [SQ_STEPS];
  logic [X_W-1:0] r_r [SQ_STEPS];
  logic [X_W-1:0] n_nxt [SQ_STEPS];
  logic [X_W-1:0] r_nxt [SQ_STEPS];

  always_comb begin
    for (int s = 0; s < SQ_STEPS; s++) begin
      logic [X_W-1:0] n_cur, r_cur, bitv;
      logic [X_W:0]   sum;
      n_cur = (s == 0) ? n_in : n_r[s-1];
      r_cur = (s == 0) ? '0 : r_r[s-1];
      bitv  = X_W'(1) << (2 * (SQ_STEPS - 1 - s));
      sum   = {1'b0, r_cur} + {1'b0, bitv};
      if ({1'b0, n_cur} >= sum) begin
        n_nxt[s] = n_cur - sum[X_W-1:0];
        r_nxt[s] = (r_cur >> 1) + bitv;
      end else begin
        n_nxt[s] = n_cur;
        r_nxt[s] = r_cur >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign root = r_r[SQ_STEPS-1][SQ_STEPS-1:0];
endmodule

// ===== rtl/core/quotient_interval_count_unit.sv =====
// quotient_interval_count_unit: top level, counts m in the quotient interval per query
//
// channel | direction | ports                                      | transfer when
// in      | input     | in_x_value, in_l_value, in_k_value         | in_valid & in_ready
// out     | output    | out_interval_count                         | out_valid & out_ready
// cfg     | input     | cfg_data (u_scaled)                        | cfg_valid & cfg_ready
//
// one query per cycle unless the output stalls; pipeline: input register, 2 multiply stages,
// 84 divider stages (one quotient bit each), 27 square root stages, output register
// rst_n clears the valid bits and sets u_scaled to one
// a stalled output freezes the whole pipeline; in_ready is high when out_ready is or the output stage is empty
`timescale 1ns / 1ps
module quotient_interval_count_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [qic_pkg::X_W-1:0] in_x_value,
  input  logic [qic_pkg::X_W-1:0] in_l_value,
  input  logic [qic_pkg::X_W-1:0] in_k_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [qic_pkg::X_W-1:0] out_interval_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [qic_pkg::U_W-1:0] cfg_data
);
  import qic_pkg::*;

  localparam int V_LEN  = 1 + MUL_LAT + DIV_W + SQ_STEPS + 1;
  localparam int LZ_LEN = MUL_LAT + DIV_W + SQ_STEPS;

  logic           en;
  logic [U_W-1:0] u_r;
  logic           valid_r [V_LEN];
  logic           lz_r    [LZ_LEN];
  logic           lz_a_r;
  logic [X_W-1:0] x_a_r, l_a_r, k_a_r;
  logic [X_W:0]   kp1_a_r;
  logic [X_W-1:0] x_d_r [MUL_LAT];
  logic [X_W-1:0] l_d_r [MUL_LAT];
  logic [Q_W-1:0] l2_d_r [SQ_STEPS];
  logic [Q_W-1:0] m2_d_r [SQ_STEPS];
  logic [Q_W-1:0] m1_d_r [SQ_STEPS];
  logic [X_W-1:0] cnt_r;

  logic [PROD_W-1:0] p_ul, p_lk, p_lk1;
  logic [Q_W-1:0]    q_l2, q_m2, q_m1, q_xl;
  logic [SQ_STEPS-1:0] root;
  logic [Q_W-1:0]    l1, m1, high, low;
  logic [Q_W:0]      span;
  logic [X_W-1:0]    cnt_nxt;

  assign en        = !valid_r[V_LEN-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= U_RESET;
    end else if (cfg_valid) begin
      u_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < V_LEN; i++) valid_r[i] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < V_LEN; i++) valid_r[i] <= valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r   <= in_x_value;
      l_a_r   <= in_l_value;
      k_a_r   <= in_k_value;
      kp1_a_r <= {1'b0, in_k_value} + (X_W+1)'(1);
      lz_a_r  <= (in_l_value == '0);
      x_d_r[0] <= x_a_r;
      l_d_r[0] <= l_a_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        x_d_r[i] <= x_d_r[i-1];
        l_d_r[i] <= l_d_r[i-1];
      end
      lz_r[0] <= lz_a_r;
      for (int i = 1; i < LZ_LEN; i++) lz_r[i] <= lz_r[i-1];
      l2_d_r[0] <= q_l2;
      m2_d_r[0] <= q_m2;
      m1_d_r[0] <= q_m1;
      for (int i = 1; i < SQ_STEPS; i++) begin
        l2_d_r[i] <= l2_d_r[i-1];
        m2_d_r[i] <= m2_d_r[i-1];
        m1_d_r[i] <= m1_d_r[i-1];
      end
      cnt_r <= cnt_nxt;
    end
  end

  qic_mul u_mul_ul (.clk(clk), .en(en), .a(u_r), .b(MUL_W'(l_a_r)), .p(p_ul));
  qic_mul u_mul_lk (.clk(clk), .en(en), .a(MUL_W'(l_a_r)), .b(MUL_W'(k_a_r)), .p(p_lk));
  qic_mul u_mul_lk1 (.clk(clk), .en(en), .a(MUL_W'(l_a_r)), .b(MUL_W'(kp1_a_r)),
                     .p(p_lk1));

  qic_div u_div_l2 (.clk(clk), .en(en),
                    .num({x_d_r[MUL_LAT-1], {FRACTION_BITS{1'b0}}}), .den(p_ul), .quo(q_l2));
  qic_div u_div_m2 (.clk(clk), .en(en), .num(DIV_W'(x_d_r[MUL_LAT-1])), .den(p_lk),
                    .quo(q_m2));
  qic_div u_div_m1 (.clk(clk), .en(en), .num(DIV_W'(x_d_r[MUL_LAT-1])), .den(p_lk1),
                    .quo(q_m1));
  qic_div u_div_xl (.clk(clk), .en(en), .num(DIV_W'(x_d_r[MUL_LAT-1])),
                    .den(PROD_W'(l_d_r[MUL_LAT-1])), .quo(q_xl));

  qic_sqrt u_sqrt (.clk(clk), .en(en), .n_in(q_xl[X_W-1:0]), .root(root));

  always_comb begin
    l1   = Q_W'(root) + Q_W'(1);
    m1   = m1_d_r[SQ_STEPS-1] + Q_W'(1);
    high = (l2_d_r[SQ_STEPS-1] < m2_d_r[SQ_STEPS-1]) ? l2_d_r[SQ_STEPS-1]
                                                       : m2_d_r[SQ_STEPS-1];
    low  = (l1 > m1) ? l1 : m1;
    span = {1'b0, high} - {1'b0, low} + (Q_W+1)'(1);
    if (lz_r[LZ_LEN-1] || high < low) begin
      cnt_nxt = '0;
    end else if (span > (Q_W+1)'(COUNT_MAX)) begin
      cnt_nxt = COUNT_MAX;
    end else begin
      cnt_nxt = span[X_W-1:0];
    end
  end

  assign out_valid          = valid_r[V_LEN-1];
  assign out_interval_count = cnt_r;

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> u_r == $past(cfg_data))
    else $error("u_scaled not taken from cfg transfer");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r[V_LEN-2]) && $stable(cnt_r))
    else $error("pipeline moved during stall");
  a_in_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted item lost at entry");
endmodule

// ===== test/quotient_interval_count_unit_tb.sv =====
// quotient_interval_count_unit_tb: self-checking testbench with a predictor for the interval count
`timescale 1ns / 1ps
module quotient_interval_count_unit_tb;
  import qic_pkg::*;

  localparam int PIPE_CYCLES = 130;

  typedef struct {
    logic [X_W-1:0] x;
    logic [X_W-1:0] l;
    logic [X_W-1:0] k;
    bit             known;
    logic [X_W-1:0] count;
  } query_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [X_W-1:0] in_x_value = '0;
  logic [X_W-1:0] in_l_value = '0;
  logic [X_W-1:0] in_k_value = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [X_W-1:0] out_interval_count;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [U_W-1:0] cfg_data = '0;

  logic [U_W-1:0] u_model;
  logic [X_W-1:0] count_q[$];
  int             errors = 0;
  bit             quiet = 1'b0;

  quotient_interval_count_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_value(in_x_value), .in_l_value(in_l_value), .in_k_value(in_k_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_interval_count(out_interval_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // truncating quotient saturated to 64 bits, zero divisor gives all ones
  function automatic logic [63:0] sat_quotient(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == '0) return '1;
    q = num / den;
    return (q[127:64] != '0) ? '1 : q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= n) root = root | (64'd1 << b);
    end
    return root;
  endfunction

  function automatic logic [X_W-1:0] interval_count(logic [X_W-1:0] x, logic [X_W-1:0] l,
                                                    logic [X_W-1:0] k);
    logic [63:0] bound_u, bound_sqrt, bound_k, bound_k1, hi, lo, span;
    if (l == '0) return '0;
    bound_u    = sat_quotient(128'(x) << FRACTION_BITS, 128'(u_model) * 128'(l));
    bound_sqrt = int_sqrt(64'(x / l)) + 64'd1;
    bound_k    = sat_quotient(128'(x), 128'(l) * 128'(k));
    bound_k1   = sat_quotient(128'(x), 128'(l) * 128'(64'(k) + 64'd1)) + 64'd1;
    hi = (bound_u < bound_k) ? bound_u : bound_k;
    lo = (bound_sqrt > bound_k1) ? bound_sqrt : bound_k1;
    if (hi < lo) return '0;
    span = hi - lo + 64'd1;
    return (span > 64'(COUNT_MAX)) ? COUNT_MAX : span[X_W-1:0];
  endfunction

  function automatic logic [X_W-1:0] rand54();
    return X_W'({$urandom, $urandom});
  endfunction

  task automatic gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_query(query_t q);
    bit acc;
    in_valid   <= 1'b1;
    in_x_value <= q.x;
    in_l_value <= q.l;
    in_k_value <= q.k;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    count_q.push_back(q.known ? q.count : interval_count(q.x, q.l, q.k));
    gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (count_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_u(logic [U_W-1:0] value);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    u_model = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic query_t random_query();
    query_t q;
    logic [X_W-1:0] m;
    q.known = 1'b0;
    q.count = '0;
    case ($urandom_range(0, 9))
      0: begin
        q.x = rand54(); q.l = rand54(); q.k = rand54();
        if ($urandom_range(0, 4) == 0) q.l = '0;
        if ($urandom_range(0, 4) == 0) q.k = '0;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: q.x = rand54() % 54'd10000000000000000;
          1: q.x = 54'($urandom);
          default: q.x = rand54() >> $urandom_range(0, 40);
        endcase
        q.l = X_W'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 20 : 5000));
        m = X_W'(int_sqrt(64'(q.x / q.l)) + 64'($urandom_range(0, 2000)));
        if (m == '0) m = 54'd1;
        q.k = (q.x / q.l) / m;
        if (q.k == '0) q.k = 54'd1;
      end
    endcase
    return q;
  endfunction

  query_t directed[] = '{
    '{54'd0, 54'd1, 54'd1, 1'b1, 54'd0},
    '{54'd12345, 54'd0, 54'd7, 1'b1, 54'd0},
    '{'1, 54'd0, '1, 1'b1, 54'd0},
    '{54'd100, 54'd1, 54'd0, 1'b0, 54'd0},
    '{54'd1000000, 54'd1, 54'd0, 1'b0, 54'd0},
    '{'1, 54'd1, 54'd1, 1'b0, 54'd0},
    '{'1, 54'd1, '1, 1'b0, 54'd0},
    '{'1, '1, '1, 1'b0, 54'd0},
    '{54'd9999999999999999, 54'd1, 54'd1, 1'b0, 54'd0},
    '{54'd9999999999999999, 54'd3, 54'd1000, 1'b0, 54'd0},
    '{54'd10000000000000000, 54'd2, 54'd5, 1'b0, 54'd0},
    '{54'd1000, '1, 54'd1, 1'b0, 54'd0},
    '{54'd1000, 54'd3, '1, 1'b0, 54'd0},
    '{54'd999999, 54'd7, 54'd100, 1'b0, 54'd0},
    '{54'd1, 54'd1, 54'd1, 1'b0, 54'd0},
    '{54'h2AAAAAAAAAAAAA, 54'h15555555555555, 54'd1, 1'b0, 54'd0}
  };

  logic [U_W-1:0] u_settings[] = '{U_RESET, '1, 64'd0, U_RESET, 64'h0000_0003_0000_0000,
                                   64'h0000_0000_6000_0000, 64'h0000_0000_4000_0001};

  initial begin
    u_model = U_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (u_settings[p]) begin
      if (p != 0) write_u(u_settings[p]);
      foreach (directed[i]) send_query(directed[i]);
      for (int n = 0; n < 91; n++) begin
        if (p == u_settings.size() - 1 && n >= 50) quiet = 1'b1;
        send_query(random_query());
      end
      drain();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // output stall bursts
  initial begin
    while (1) begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (count_q.size() == 0) begin
        $error("unexpected transfer: interval_count actual %0d", out_interval_count);
        errors++;
      end else begin
        if (out_interval_count !== count_q[0]) begin
          $error("interval_count expected %0d actual %0d", count_q[0], out_interval_count);
          errors++;
        end
        void'(count_q.pop_front());
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
